### design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table and its cells.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_UPDATE = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_LOOKUP = 3'd3;
  localparam logic [2:0] KIND_LIST   = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACT,
    S_LIST
  } skt_state_e;

  typedef enum logic [2:0] {
    M_HOLD,
    M_CMP,
    M_INS,
    M_DEL,
    M_UPD,
    M_ROT
  } skt_mode_e;

  typedef struct packed {
    logic        [2:0]  kind;
    logic signed [31:0] key;
    logic        [31:0] value;
  } skt_in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] out_key;
    logic        [31:0] out_value;
    logic               last;
  } skt_out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] value;
  } skt_entry_t;

  typedef struct packed {
    skt_mode_e          mode;
    logic signed [31:0] key;
    logic        [31:0] value;
  } skt_cmd_t;

endpackage

### design/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the table: holds an entry, compares it with the broadcast key
// and shifts, updates or rotates it under the broadcast command.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic                clk_i,
  input  skt_pkg::skt_cmd_t   cmd_i,
  input  logic                occ_i,
  input  logic                prev_sel_i,
  input  skt_pkg::skt_entry_t prev_i,
  input  skt_pkg::skt_entry_t next_i,
  input  logic                next_occ_i,
  input  skt_pkg::skt_entry_t head_i,
  output skt_pkg::skt_entry_t entry_o,
  output logic                sel_o,
  output logic                eq_o
);

  skt_pkg::skt_entry_t entry_q, entry_d;
  logic                sel_q, sel_d;
  logic                eq_q, eq_d;

  always_comb begin
    entry_d = entry_q;
    sel_d   = sel_q;
    eq_d    = eq_q;
    unique case (cmd_i.mode)
      skt_pkg::M_CMP: begin
        sel_d = !occ_i || ($signed(entry_q.key) >= $signed(cmd_i.key));
        eq_d  = occ_i && (entry_q.key == cmd_i.key);
      end
      skt_pkg::M_INS: begin
        if (sel_q) begin
          if (prev_sel_i) begin
            entry_d = prev_i;
          end else begin
            entry_d.key   = cmd_i.key;
            entry_d.value = cmd_i.value;
          end
        end
      end
      skt_pkg::M_DEL: begin
        if (sel_q) begin
          entry_d = next_i;
        end
      end
      skt_pkg::M_UPD: begin
        if (eq_q) begin
          entry_d.value = cmd_i.value;
        end
      end
      skt_pkg::M_ROT: begin
        if (occ_i) begin
          entry_d = next_occ_i ? next_i : head_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    sel_q   <= sel_d;
    eq_q    <= eq_d;
  end

  assign entry_o = entry_q;
  assign sel_o   = sel_q;
  assign eq_o    = eq_q;

endmodule

### design/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Ordered table of signed keys with value words, kept in a chain of cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It carries an
// operation (insert, update, delete, lookup, list), a key and a value word.
// Every cell compares its key with the item's key at the edge that takes the
// item, and the next cycle shifts the chain, writes a value or picks the
// matching entry. Insert, update, delete and lookup give one result per
// item, shown on result_o for one cycle with result_valid_o high, in the
// cycle after the work cycle.
// List rotates the occupied cells toward the head, one entry per cycle, and
// emits the head each cycle; it marks its final result with last. Items with
// an unused operation code are dropped and give no result.
// The receiver cannot stall: every result is presented for exactly one cycle.
// Reset empties the table; entry contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  skt_pkg::skt_in_t  in_i,
  output logic              result_valid_o,
  output skt_pkg::skt_out_t result_o
);

  localparam int unsigned N = skt_pkg::CAPACITY;

  skt_pkg::skt_state_e state_q, state_d;
  skt_pkg::skt_in_t    op_q;
  logic [skt_pkg::CNT_W-1:0] count_q, count_d;
  logic [skt_pkg::IDX_W-1:0] idx_q, idx_d;
  skt_pkg::skt_out_t   res_q, res_d;
  logic                res_valid_q, res_valid_d;

  skt_pkg::skt_cmd_t   cmd;
  skt_pkg::skt_entry_t entry [N];
  logic [N-1:0]        sel;
  logic [N-1:0]        eq;
  logic [N-1:0]        occ;

  logic                hit;
  logic                full;
  logic                empty;
  logic                list_last;
  logic signed [31:0]  found_key;
  logic        [31:0]  found_value;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      assign occ[g] = (skt_pkg::CNT_W'(g) < count_q);
      skt_cell u_cell (
        .clk_i      (clk_i),
        .cmd_i      (cmd),
        .occ_i      (occ[g]),
        .prev_sel_i ((g == 0) ? 1'b0 : sel[(g == 0) ? 0 : g - 1]),
        .prev_i     (entry[(g == 0) ? 0 : g - 1]),
        .next_i     (entry[(g == N - 1) ? g : g + 1]),
        .next_occ_i ((g == N - 1) ? 1'b0 : occ[(g == N - 1) ? g : g + 1]),
        .head_i     (entry[0]),
        .entry_o    (entry[g]),
        .sel_o      (sel[g]),
        .eq_o       (eq[g])
      );
    end
  endgenerate

  always_comb begin
    found_key   = '0;
    found_value = '0;
    for (int i = 0; i < N; i++) begin
      found_key   = found_key | (eq[i] ? entry[i].key : 32'sd0);
      found_value = found_value | (eq[i] ? entry[i].value : 32'd0);
    end
  end

  assign hit       = |eq;
  assign full      = (count_q == skt_pkg::CNT_W'(N));
  assign empty     = (count_q == '0);
  assign list_last = empty ||
                     ((skt_pkg::CNT_W'(idx_q) + skt_pkg::CNT_W'(1)) == count_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        if (start) begin
          if (in_i.kind == skt_pkg::KIND_LIST) begin
            state_d = skt_pkg::S_LIST;
          end else if (in_i.kind < skt_pkg::KIND_LIST) begin
            state_d = skt_pkg::S_ACT;
          end
        end
      end
      skt_pkg::S_ACT: begin
        state_d = skt_pkg::S_IDLE;
      end
      skt_pkg::S_LIST: begin
        if (list_last) begin
          state_d = skt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.mode    = skt_pkg::M_HOLD;
    cmd.key     = op_q.key;
    cmd.value   = op_q.value;
    count_d     = count_q;
    idx_d       = idx_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    unique case (state_q)
      skt_pkg::S_IDLE: begin
        busy    = 1'b0;
        cmd.key = in_i.key;
        idx_d   = '0;
        if (start) begin
          cmd.mode = skt_pkg::M_CMP;
        end
      end
      skt_pkg::S_ACT: begin
        res_valid_d = 1'b1;
        unique case (op_q.kind)
          skt_pkg::KIND_INSERT: begin
            if (hit) begin
              res_d.status = skt_pkg::ST_DUP;
            end else if (full) begin
              res_d.status = skt_pkg::ST_FULL;
            end else begin
              res_d.status = skt_pkg::ST_OK;
              cmd.mode     = skt_pkg::M_INS;
              count_d      = count_q + skt_pkg::CNT_W'(1);
            end
          end
          default: begin
            if (empty) begin
              res_d.status = skt_pkg::ST_EMPTY;
            end else if (!hit) begin
              res_d.status = skt_pkg::ST_MISSING;
            end else begin
              res_d.status = skt_pkg::ST_OK;
              if (op_q.kind == skt_pkg::KIND_UPDATE) begin
                cmd.mode = skt_pkg::M_UPD;
              end else if (op_q.kind == skt_pkg::KIND_DELETE) begin
                cmd.mode = skt_pkg::M_DEL;
                count_d  = count_q - skt_pkg::CNT_W'(1);
              end else begin
                res_d.out_key   = found_key;
                res_d.out_value = found_value;
              end
            end
          end
        endcase
      end
      skt_pkg::S_LIST: begin
        res_valid_d = 1'b1;
        res_d.last  = list_last;
        if (empty) begin
          res_d.status = skt_pkg::ST_EMPTY;
        end else begin
          res_d.status    = skt_pkg::ST_OK;
          res_d.out_key   = entry[0].key;
          res_d.out_value = entry[0].value;
          cmd.mode        = skt_pkg::M_ROT;
          idx_d           = idx_q + skt_pkg::IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skt_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == skt_pkg::S_IDLE && start) begin
      op_q <= in_i;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
